FILE: sv/dnsp_pkg.sv
// Shared types and constants for the DNS response parser.
package dnsp_pkg;

  typedef enum logic [3:0] {
    PH_HEADER = 4'd0,
    PH_QLEN   = 4'd1,
    PH_QLABEL = 4'd2,
    PH_QTAIL  = 4'd3,
    PH_AFIX   = 4'd4,
    PH_RDATA  = 4'd5,
    PH_DONE   = 4'd6
  } parse_phase_e;

  typedef enum logic [1:0] {
    REC_HEADER    = 2'd0,
    REC_QUESTION  = 2'd1,
    REC_ANSWER    = 2'd2,
    REC_MALFORMED = 2'd3
  } rec_kind_e;

  localparam logic [15:0] HDR_LAST      = 16'd11;  // last header byte
  localparam logic [15:0] HDR_STORE_END = 16'd8;   // id, flags, qd and an counts
  localparam logic [15:0] QTAIL_LAST    = 16'd3;   // qtype and qclass
  localparam logic [15:0] AFIX_LAST     = 16'd11;  // pointer .. rdata length
  localparam logic [15:0] ADDR_BYTES    = 16'd4;
  localparam logic [13:0] QNAME_OFFSET  = 14'd12;

  typedef struct packed {
    rec_kind_e   kind;
    logic [15:0] msg_id;
    logic [15:0] hdr_flags;
    logic [15:0] question_count;
    logic [15:0] answer_count;
    logic [13:0] name_offset;
    logic        name_is_question;
    logic [15:0] rtype;
    logic [15:0] rclass;
    logic [31:0] ttl_seconds;
    logic [15:0] rdata_len;
    logic [31:0] ipv4_address;
  } rec_t;

endpackage

FILE: sv/dnsp_parse_core.sv
// Parse state and per-byte update logic of the DNS response parser.
module dnsp_parse_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           word_valid_i,
  input  logic           fire_i,
  input  logic [7:0]     data_byte_i,
  input  logic           last_byte_i,
  output logic           res_valid_o,
  output dnsp_pkg::rec_t res_o
);
  import dnsp_pkg::*;

  parse_phase_e      phase_q, phase_d, phase_u;
  logic [15:0]       cnt_q, cnt_d, cnt_u, cnt_inc;
  logic [3:0][15:0]  hdr_q, hdr_d, hdr_u;
  logic [15:0]       ans_q, ans_d, ans_u, ans_left;
  logic [7:0]        label_q, label_d, label_u;
  logic [13:0]       ptr_q, ptr_d, ptr_u;
  logic [15:0]       type_q, type_d, type_u;
  logic [15:0]       cls_q, cls_d, cls_u;
  logic [31:0]       ttl_q, ttl_d, ttl_u;
  logic [15:0]       len_q, len_d, len_u;
  logic [31:0]       addr_q, addr_d, addr_u;
  logic              hdr_done, q_done, ans_done, malformed;

  assign cnt_inc  = cnt_q + 16'd1;
  assign ans_left = ans_q - 16'd1;

  // Effect of the current word on the parse state
  always_comb begin
    phase_u  = phase_q;
    cnt_u    = cnt_q;
    hdr_u    = hdr_q;
    ans_u    = ans_q;
    label_u  = label_q;
    ptr_u    = ptr_q;
    type_u   = type_q;
    cls_u    = cls_q;
    ttl_u    = ttl_q;
    len_u    = len_q;
    addr_u   = addr_q;
    hdr_done = 1'b0;
    q_done   = 1'b0;
    ans_done = 1'b0;
    case (phase_q)
      PH_HEADER: begin
        if (cnt_q < HDR_STORE_END) begin
          if (!cnt_q[0]) hdr_u[cnt_q[2:1]][15:8] = data_byte_i;
          else           hdr_u[cnt_q[2:1]][7:0]  = data_byte_i;
        end
        cnt_u = cnt_inc;
        if (cnt_q == HDR_LAST) begin
          ans_u    = hdr_q[3];
          cnt_u    = '0;
          phase_u  = PH_QLEN;
          hdr_done = 1'b1;
        end
      end
      PH_QLEN: begin
        if (data_byte_i == 8'd0) begin
          cnt_u   = '0;
          phase_u = PH_QTAIL;
        end else begin
          label_u = data_byte_i;
          phase_u = PH_QLABEL;
        end
      end
      PH_QLABEL: begin
        label_u = label_q - 8'd1;
        if (label_q == 8'd1) phase_u = PH_QLEN;
      end
      PH_QTAIL: begin
        cnt_u = cnt_inc;
        if (cnt_q == QTAIL_LAST) begin
          cnt_u   = '0;
          phase_u = (ans_q == 16'd0) ? PH_DONE : PH_AFIX;
          q_done  = 1'b1;
        end
      end
      PH_AFIX: begin
        case (cnt_q[3:0])
          4'd0:    ptr_u  = {data_byte_i[5:0], 8'h00};
          4'd1:    ptr_u  = ptr_q | {6'd0, data_byte_i};
          4'd2:    type_u = {data_byte_i, 8'h00};
          4'd3:    type_u = type_q | {8'h00, data_byte_i};
          4'd4:    cls_u  = {data_byte_i, 8'h00};
          4'd5:    cls_u  = cls_q | {8'h00, data_byte_i};
          4'd6, 4'd7, 4'd8, 4'd9:
                   ttl_u  = {ttl_q[23:0], data_byte_i};
          4'd10:   len_u  = {data_byte_i, 8'h00};
          default: len_u  = len_q | {8'h00, data_byte_i};
        endcase
        cnt_u = cnt_inc;
        if (cnt_q == AFIX_LAST) begin
          cnt_u = '0;
          if (len_u == 16'd0) ans_done = 1'b1;
          else                phase_u  = PH_RDATA;
        end
      end
      PH_RDATA: begin
        if (cnt_q < ADDR_BYTES) begin
          case (cnt_q[1:0])
            2'd0:    addr_u[31:24] = addr_q[31:24] | data_byte_i;
            2'd1:    addr_u[23:16] = addr_q[23:16] | data_byte_i;
            2'd2:    addr_u[15:8]  = addr_q[15:8]  | data_byte_i;
            default: addr_u[7:0]   = addr_q[7:0]   | data_byte_i;
          endcase
        end
        cnt_u = cnt_inc;
        if (cnt_inc >= len_q) ans_done = 1'b1;
      end
      default: ;
    endcase
    if (ans_done) begin
      ans_u   = ans_left;
      cnt_u   = '0;
      phase_u = (ans_left == 16'd0) ? PH_DONE : PH_AFIX;
    end
  end

  assign malformed = last_byte_i && (phase_u != PH_DONE);

  // Next state: finished record clears the pending fields, end of message clears all
  always_comb begin
    phase_d = phase_u;
    cnt_d   = cnt_u;
    hdr_d   = hdr_u;
    ans_d   = ans_u;
    label_d = label_u;
    ptr_d   = ans_done ? '0 : ptr_u;
    type_d  = ans_done ? '0 : type_u;
    cls_d   = ans_done ? '0 : cls_u;
    ttl_d   = ans_done ? '0 : ttl_u;
    len_d   = ans_done ? '0 : len_u;
    addr_d  = ans_done ? '0 : addr_u;
    if (last_byte_i) begin
      phase_d = PH_HEADER;
      cnt_d   = '0;
      hdr_d   = '0;
      ans_d   = '0;
      label_d = '0;
      ptr_d   = '0;
      type_d  = '0;
      cls_d   = '0;
      ttl_d   = '0;
      len_d   = '0;
      addr_d  = '0;
    end
  end

  // Result word
  always_comb begin
    res_valid_o = word_valid_i && (hdr_done || q_done || ans_done || malformed);
    res_o                = '0;
    res_o.msg_id         = hdr_u[0];
    res_o.hdr_flags      = hdr_u[1];
    res_o.question_count = hdr_u[2];
    res_o.answer_count   = hdr_u[3];
    if (malformed) begin
      res_o.kind = REC_MALFORMED;
    end else if (ans_done) begin
      res_o.kind             = REC_ANSWER;
      res_o.name_offset      = ptr_u;
      res_o.name_is_question = (ptr_u == QNAME_OFFSET);
      res_o.rtype            = type_u;
      res_o.rclass           = cls_u;
      res_o.ttl_seconds      = ttl_u;
      res_o.rdata_len        = len_u;
      res_o.ipv4_address     = addr_u;
    end else if (q_done) begin
      res_o.kind = REC_QUESTION;
    end else begin
      res_o.kind = REC_HEADER;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      hdr_q   <= '0;
      ans_q   <= '0;
      label_q <= '0;
      ptr_q   <= '0;
      type_q  <= '0;
      cls_q   <= '0;
      ttl_q   <= '0;
      len_q   <= '0;
      addr_q  <= '0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      hdr_q   <= hdr_d;
      ans_q   <= ans_d;
      label_q <= label_d;
      ptr_q   <= ptr_d;
      type_q  <= type_d;
      cls_q   <= cls_d;
      ttl_q   <= ttl_d;
      len_q   <= len_d;
      addr_q  <= addr_d;
    end
  end

  a_done_no_answers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_DONE |-> ans_q == 16'd0)
    else $error("parse done with answers outstanding");

  a_label_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_QLABEL |-> label_q != 8'd0)
    else $error("label phase with empty label");

  a_rdata_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_RDATA |-> (len_q != 16'd0) && (cnt_q < len_q))
    else $error("rdata count beyond rdata length");

  a_afix_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_AFIX |-> cnt_q <= AFIX_LAST)
    else $error("answer fixed field count out of range");

endmodule

FILE: sv/dns_response_parser.sv
// Top level of the DNS response parser: input register, parse core, result register.
//
// Usage:
//   Message bytes enter on the input channel (in_valid_i / in_stall_o), one
//   word per byte, with last_byte_i set on the final byte of a message.
//   Result words leave on the output channel (out_valid_o / out_stall_i):
//   a header word after byte 12, a question word after the question tail,
//   one answer word per record, or a malformed word when the message ends
//   before the parse is complete. Header fields ride on every word; answer
//   fields are zero except in answer words.
//   A result word is registered: the byte sits in the input register, and the
//   result register loads from it when the byte moves on.
//   One byte per cycle is sustained unless a held result blocks the byte; the
//   per-byte parse update is combinational between the input and result registers.
//   When the receiver stalls with a result held, a byte that yields no
//   result still goes through; a byte that yields one waits in the input
//   register and in_stall_o rises once that register is occupied.
//   Reset clears the parse state to the start of a message and empties both
//   registers. After each last byte the parser returns to that state.
module dns_response_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  rec_kind_o,
  output logic [15:0] msg_id_o,
  output logic [15:0] hdr_flags_o,
  output logic [15:0] question_count_o,
  output logic [15:0] answer_count_o,
  output logic [13:0] name_offset_o,
  output logic        name_is_question_o,
  output logic [15:0] rtype_o,
  output logic [15:0] rclass_o,
  output logic [31:0] ttl_seconds_o,
  output logic [15:0] rdata_len_o,
  output logic [31:0] ipv4_address_o
);
  import dnsp_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       in_load, fire, res_valid, out_take;
  logic       out_valid_q, out_valid_d;
  rec_t       res, out_q;

  dnsp_parse_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .word_valid_i (in_valid_q),
    .fire_i       (fire),
    .data_byte_i  (byte_q),
    .last_byte_i  (last_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  assign out_take    = out_valid_q && !out_stall_i;
  // a byte moves on unless it has a result and the result slot is blocked
  assign fire        = in_valid_q && (!res_valid || !out_valid_q || !out_stall_i);
  assign in_stall_o  = in_valid_q && !fire;
  assign in_load     = in_valid_i && !in_stall_o;
  assign in_valid_d  = in_load ? 1'b1 : (fire ? 1'b0 : in_valid_q);
  assign out_valid_d = (fire && res_valid) ? 1'b1 : (out_take ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load) begin
      byte_q <= data_byte_i;
      last_q <= last_byte_i;
    end
    if (fire && res_valid) out_q <= res;
  end

  assign out_valid_o        = out_valid_q;
  assign rec_kind_o         = out_q.kind;
  assign msg_id_o           = out_q.msg_id;
  assign hdr_flags_o        = out_q.hdr_flags;
  assign question_count_o   = out_q.question_count;
  assign answer_count_o     = out_q.answer_count;
  assign name_offset_o      = out_q.name_offset;
  assign name_is_question_o = out_q.name_is_question;
  assign rtype_o            = out_q.rtype;
  assign rclass_o           = out_q.rclass;
  assign ttl_seconds_o      = out_q.ttl_seconds;
  assign rdata_len_o        = out_q.rdata_len;
  assign ipv4_address_o     = out_q.ipv4_address;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_result_from_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_valid_q))
    else $error("result appeared without a word in process");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q))
    else $error("held result lost or overwritten");

endmodule

FILE: verif/tb_dns_response_parser.sv
// Self-checking testbench for the DNS response parser: message stimulus, parse predictor, record checks.
`timescale 1ns / 100ps

module tb_dns_response_parser;
  import dnsp_pkg::*;

  localparam int unsigned STALL_LIMIT    = 2000;  // cycles with no word moving on either side
  localparam int unsigned HOLDOFF_CYCLES = 300;
  localparam int unsigned DRAIN_GAP      = 6;
  localparam int unsigned PHASE_BYTES    = 10;

  // Mirrors the parse state and queues the records that each accepted byte should give.
  class dns_scoreboard;
    parse_phase_e phase;
    logic [15:0]  byte_cnt;
    logic [15:0]  hdr_word [4];
    logic [15:0]  answers_left;
    logic [7:0]   label_left;
    logic [13:0]  ptr;
    logic [15:0]  rtype;
    logic [15:0]  rclass;
    logic [31:0]  ttl;
    logic [15:0]  rlen;
    logic [31:0]  addr;
    rec_t         expected_q [$];
    int unsigned  failures;
    int unsigned  bytes_seen;
    int unsigned  messages_seen;
    int unsigned  kind_seen [4];

    function new();
      failures      = 0;
      bytes_seen    = 0;
      messages_seen = 0;
      foreach (kind_seen[k]) kind_seen[k] = 0;
      restart();
    endfunction

    function void clear_answer();
      ptr    = '0;
      rtype  = '0;
      rclass = '0;
      ttl    = '0;
      rlen   = '0;
      addr   = '0;
    endfunction

    function void restart();
      phase        = PH_HEADER;
      byte_cnt     = '0;
      answers_left = '0;
      label_left   = '0;
      foreach (hdr_word[k]) hdr_word[k] = '0;
      clear_answer();
    endfunction

    function rec_t header_rec(rec_kind_e k);
      rec_t r;
      r                = '0;
      r.kind           = k;
      r.msg_id         = hdr_word[0];
      r.hdr_flags      = hdr_word[1];
      r.question_count = hdr_word[2];
      r.answer_count   = hdr_word[3];
      return r;
    endfunction

    // Record complete: build the answer word and move on to the next record or to done.
    function rec_t close_answer();
      rec_t r;
      r                  = header_rec(REC_ANSWER);
      r.name_offset      = ptr;
      r.name_is_question = (ptr == QNAME_OFFSET);
      r.rtype            = rtype;
      r.rclass           = rclass;
      r.ttl_seconds      = ttl;
      r.rdata_len        = rlen;
      r.ipv4_address     = addr;
      clear_answer();
      answers_left = answers_left - 16'd1;
      phase = (answers_left == 16'd0) ? PH_DONE : PH_AFIX;
      return r;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      rec_t        r;
      bit          emit;
      logic [15:0] c;
      logic [1:0]  w;
      emit = 1'b0;
      r    = '0;
      c    = byte_cnt;
      bytes_seen++;
      case (phase)
        PH_HEADER: begin
          if (c < HDR_STORE_END) begin
            w = c[2:1];
            if (!c[0]) hdr_word[w][15:8] = b;
            else hdr_word[w][7:0] = b;
          end
          if (c == HDR_LAST) begin
            answers_left = hdr_word[3];
            c     = '0;
            phase = PH_QLEN;
            r     = header_rec(REC_HEADER);
            emit  = 1'b1;
          end else begin
            c = c + 16'd1;
          end
        end
        PH_QLEN: begin
          if (b == 8'd0) begin
            c     = '0;
            phase = PH_QTAIL;
          end else begin
            label_left = b;
            phase      = PH_QLABEL;
          end
        end
        PH_QLABEL: begin
          label_left = label_left - 8'd1;
          if (label_left == 8'd0) phase = PH_QLEN;
        end
        PH_QTAIL: begin
          if (c == QTAIL_LAST) begin
            c     = '0;
            phase = (answers_left == 16'd0) ? PH_DONE : PH_AFIX;
            r     = header_rec(REC_QUESTION);
            emit  = 1'b1;
          end else begin
            c = c + 16'd1;
          end
        end
        PH_AFIX: begin
          case (c)
            16'd0: ptr = {b[5:0], 8'h00};  // tag bits dropped unchecked
            16'd1: ptr[7:0] = b;
            16'd2: rtype = {b, 8'h00};
            16'd3: rtype[7:0] = b;
            16'd4: rclass = {b, 8'h00};
            16'd5: rclass[7:0] = b;
            16'd6, 16'd7, 16'd8, 16'd9: ttl = {ttl[23:0], b};
            16'd10: rlen = {b, 8'h00};
            default: rlen[7:0] = b;
          endcase
          if (c == AFIX_LAST) begin
            c = '0;
            if (rlen == 16'd0) begin
              r    = close_answer();
              emit = 1'b1;
            end else begin
              phase = PH_RDATA;
            end
          end else begin
            c = c + 16'd1;
          end
        end
        PH_RDATA: begin
          if (c < ADDR_BYTES) addr = addr | ({24'h0, b} << (8 * (3 - c[1:0])));
          c = c + 16'd1;
          if (c >= rlen) begin
            r    = close_answer();
            emit = 1'b1;
            c    = '0;
          end
        end
        default: ;
      endcase
      byte_cnt = c;
      if (last) begin
        // an unfinished parse at the last byte overrides whatever this byte gave
        if (phase != PH_DONE) begin
          r    = header_rec(REC_MALFORMED);
          emit = 1'b1;
        end
        messages_seen++;
        restart();
      end
      if (emit) expected_q.push_back(r);
    endfunction

    function void cmp(string name, logic [31:0] e, logic [31:0] a);
      if (e !== a) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, e, a);
        failures++;
      end
    endfunction

    function void check_record(rec_t got);
      rec_t e;
      if (expected_q.size() == 0) begin
        $error("result word of kind %0d with nothing expected", got.kind);
        failures++;
        return;
      end
      e = expected_q.pop_front();
      kind_seen[e.kind]++;
      cmp("rec_kind", e.kind, got.kind);
      cmp("msg_id", e.msg_id, got.msg_id);
      cmp("hdr_flags", e.hdr_flags, got.hdr_flags);
      cmp("question_count", e.question_count, got.question_count);
      cmp("answer_count", e.answer_count, got.answer_count);
      cmp("name_offset", e.name_offset, got.name_offset);
      cmp("name_is_question", e.name_is_question, got.name_is_question);
      cmp("rtype", e.rtype, got.rtype);
      cmp("rclass", e.rclass, got.rclass);
      cmp("ttl_seconds", e.ttl_seconds, got.ttl_seconds);
      cmp("rdata_len", e.rdata_len, got.rdata_len);
      cmp("ipv4_address", e.ipv4_address, got.ipv4_address);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  rec_kind_o;
  logic [15:0] msg_id_o;
  logic [15:0] hdr_flags_o;
  logic [15:0] question_count_o;
  logic [15:0] answer_count_o;
  logic [13:0] name_offset_o;
  logic        name_is_question_o;
  logic [15:0] rtype_o;
  logic [15:0] rclass_o;
  logic [31:0] ttl_seconds_o;
  logic [15:0] rdata_len_o;
  logic [31:0] ipv4_address_o;

  dns_scoreboard sb = new();

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  int unsigned tx_plan [4]  = '{0, 54, 0, 22};
  int unsigned rx_plan [4]  = '{0, 0, 54, 22};
  bit          holdoff_req  = 1'b0;
  logic [7:0]  msg_bytes [$];

  dns_response_parser uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .data_byte_i        (data_byte_i),
    .last_byte_i        (last_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .rec_kind_o         (rec_kind_o),
    .msg_id_o           (msg_id_o),
    .hdr_flags_o        (hdr_flags_o),
    .question_count_o   (question_count_o),
    .answer_count_o     (answer_count_o),
    .name_offset_o      (name_offset_o),
    .name_is_question_o (name_is_question_o),
    .rtype_o            (rtype_o),
    .rclass_o           (rclass_o),
    .ttl_seconds_o      (ttl_seconds_o),
    .rdata_len_o        (rdata_len_o),
    .ipv4_address_o     (ipv4_address_o)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------- message building
  function automatic void push16(logic [15:0] v);
    msg_bytes.push_back(v[15:8]);
    msg_bytes.push_back(v[7:0]);
  endfunction

  function automatic void push_header(logic [15:0] id, logic [15:0] flags,
                                      logic [15:0] qd, logic [15:0] an);
    push16(id);
    push16(flags);
    push16(qd);
    push16(an);
    push16(16'($urandom));  // ns and ar counts, ignored by the parser
    push16(16'($urandom));
  endfunction

  function automatic int unsigned pick_label_len();
    if ($urandom_range(99) < 3) return $urandom_range(9, 255);
    return $urandom_range(1, 8);
  endfunction

  // len_fixed of zero picks a random length per label
  function automatic void push_question(int unsigned n_labels, int unsigned len_fixed);
    int unsigned len;
    repeat (n_labels) begin
      len = (len_fixed != 0) ? len_fixed : pick_label_len();
      msg_bytes.push_back(8'(len));
      repeat (len) msg_bytes.push_back(8'($urandom));
    end
    msg_bytes.push_back(8'h00);
    repeat (4) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic void push_answer(logic [15:0] ptr, logic [15:0] rtype,
                                      logic [15:0] rclass, logic [31:0] ttl,
                                      logic [15:0] rlen);
    push16(ptr);
    push16(rtype);
    push16(rclass);
    push16(ttl[31:16]);
    push16(ttl[15:0]);
    push16(rlen);
    repeat (rlen) msg_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [15:0] pick_rdata_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return 16'd4;
    if (r < 97) return 16'($urandom_range(0, 8));
    return 16'($urandom_range(9, 300));
  endfunction

  function automatic logic [15:0] pick_pointer();
    if ($urandom_range(99) < 60) return 16'hc00c;
    return 16'($urandom);
  endfunction

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(logic [7:0] b, logic last);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_byte(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
    msg_bytes.delete();
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.expected_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_GAP) @(negedge clk_i);
  endtask

  task automatic directed_messages();
    // lone byte: malformed, id high byte only
    msg_bytes.push_back(8'hff);
    send_message();
    // message ends on the last header byte
    push_header(16'hffff, 16'h0000, 16'hffff, 16'h0000);
    send_message();
    // root name, no answers, ends exactly at the question tail
    push_header(16'h0000, 16'hffff, 16'h0000, 16'h0000);
    push_question(0, 0);
    send_message();
    // no answers, trailing bytes ignored
    push_header(16'h1234, 16'h8180, 16'h0001, 16'h0000);
    push_question(2, 0);
    repeat (3) msg_bytes.push_back(8'($urandom));
    send_message();
    // one full-width answer
    push_header(16'hbeef, 16'h8180, 16'h0001, 16'h0001);
    push_question(1, 3);
    push_answer(16'hc00c, 16'hffff, 16'hffff, 32'hffff_ffff, 16'd4);
    send_message();
    // empty, short and long rdata; pointer tag bits left unchecked
    push_header(16'h5a5a, 16'h0100, 16'h0001, 16'h0003);
    push_question(1, 1);
    push_answer(16'h3fff, 16'h0000, 16'h0000, 32'h0000_0000, 16'd0);
    push_answer(16'h400c, 16'h0001, 16'h0001, 32'h8000_0001, 16'd2);
    push_answer(16'h000c, 16'h001c, 16'h00ff, 32'h0001_5180, 16'd6);
    send_message();
    // cut inside rdata
    push_header(16'hcafe, 16'h8180, 16'h0001, 16'h0001);
    push_question(1, 2);
    push_answer(16'hc00c, 16'h0001, 16'h0001, 32'h0000_0e10, 16'd4);
    void'(msg_bytes.pop_back());
    send_message();
    // far more answers announced than present
    push_header(16'h7777, 16'h8180, 16'h0001, 16'hffff);
    push_question(1, 4);
    push_answer(16'hc00c, 16'h0001, 16'h0001, 32'h0000_0001, 16'd4);
    send_message();
  endtask

  task automatic random_message();
    int unsigned pick;
    int unsigned n_ans;
    logic [15:0] an_field;
    pick = $urandom_range(99);
    if (pick < 10) begin
      repeat ($urandom_range(1, 20)) msg_bytes.push_back(8'($urandom));
    end else begin
      n_ans    = $urandom_range(0, 3);
      an_field = 16'(n_ans);
      if ($urandom_range(9) == 0) an_field = 16'($urandom);
      push_header(16'($urandom), 16'($urandom), 16'($urandom), an_field);
      push_question($urandom_range(0, 3), 0);
      repeat (n_ans) begin
        push_answer(pick_pointer(), 16'($urandom), 16'($urandom), $urandom,
                    pick_rdata_len());
      end
      if ($urandom_range(3) == 0) begin
        repeat ($urandom_range(1, 4)) msg_bytes.push_back(8'($urandom));
      end
      // broken message: cut short at a random point
      if (pick < 25) begin
        repeat ($urandom_range(0, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
      end
    end
    send_message();
  endtask

  // ---------------------------------------------------------------- receiver and monitor
  initial begin : receiver
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (holdoff_req) begin
        holdoff_req = 1'b0;
        hold_left   = HOLDOFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    rec_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind             = rec_kind_e'(rec_kind_o);
      got.msg_id           = msg_id_o;
      got.hdr_flags        = hdr_flags_o;
      got.question_count   = question_count_o;
      got.answer_count     = answer_count_o;
      got.name_offset      = name_offset_o;
      got.name_is_question = name_is_question_o;
      got.rtype            = rtype_o;
      got.rclass           = rclass_o;
      got.ttl_seconds      = ttl_seconds_o;
      got.rdata_len        = rdata_len_o;
      got.ipv4_address     = ipv4_address_o;
      sb.check_record(got);
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no word moved for %0d cycles", STALL_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------- sequence
  initial begin : main
    int unsigned phase_mark;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    directed_messages();
    drain();

    for (int p = 0; p < 4; p++) begin
      tx_idle_pct  = tx_plan[p];
      rx_stall_pct = rx_plan[p];
      if (p == 0) begin
        // long receiver hold-off while bytes keep coming: fills the block
        holdoff_req = 1'b1;
        push_header(16'h4242, 16'h8180, 16'h0001, 16'h0002);
        push_question(1, 2);
        repeat (2) push_answer(pick_pointer(), 16'h0001, 16'h0001, $urandom, 16'd0);
        send_message();
      end
      phase_mark = sb.bytes_seen;
      while (sb.bytes_seen - phase_mark < PHASE_BYTES) random_message();
      // sender waits here until every expected word is back
      drain();
    end

    if (sb.expected_q.size() != 0) begin
      $error("%0d expected result words never arrived", sb.expected_q.size());
      sb.failures++;
    end
    $display("Covered %0d bytes in %0d messages under four idle/stall mixes.",
             sb.bytes_seen, sb.messages_seen);
    $display("Checked %0d header, %0d question, %0d answer and %0d malformed words.",
             sb.kind_seen[REC_HEADER], sb.kind_seen[REC_QUESTION],
             sb.kind_seen[REC_ANSWER], sb.kind_seen[REC_MALFORMED]);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
